// File: sv/ncs_pkg.sv
// Shared types, constants and codes of the nearest crystal search block.
package ncs_pkg;

  // Fixed field widths
  localparam int COORD_WIDTH   = 16;
  localparam int INDEX_WIDTH   = 10;
  localparam int COUNT_WIDTH   = 11;
  localparam int MAXD_WIDTH    = 16;
  localparam int SQ_WIDTH      = 2 * COORD_WIDTH;
  localparam int DIST_WIDTH    = SQ_WIDTH + 2;
  localparam int LIMIT_WIDTH   = 2 * MAXD_WIDTH;
  localparam int ENTRY_WIDTH   = 3 * COORD_WIDTH;
  localparam int MAX_CRYSTALS_DEF = 1024;

  // APB address map
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  // Register indexes
  localparam logic REG_CRYSTAL_COUNT = 1'b0;
  localparam logic REG_MAX_DISTANCE  = 1'b1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                           operation;
    logic [INDEX_WIDTH-1:0]         entry_index;
    logic signed [COORD_WIDTH-1:0]  pos_x;
    logic signed [COORD_WIDTH-1:0]  pos_y;
    logic signed [COORD_WIDTH-1:0]  pos_z;
  } ncs_in_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] crystal_index;
    logic                   matched;
  } ncs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } ncs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    logic query_start;
    logic issue;
    logic report;
  } ncs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_empty;
    logic scan_last;
    logic pipe_busy;
  } ncs_stat_t;

endpackage

// File: sv/ncs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ncs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ncs_ctrl.sv
// Sequencer of the nearest crystal search: accepts beats and steps a query scan.
module ncs_ctrl
  import ncs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      op,
  input  ncs_stat_t stat,
  output logic      busy,
  output ncs_cmd_t  cmd
);

  ncs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && op == OP_QUERY) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_empty)     state_nxt = ST_REPORT;
        else if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy            = 1'b0;
        cmd.load_we     = start && op == OP_LOAD;
        cmd.query_start = start && op == OP_QUERY;
      end
      ST_SCAN: begin
        cmd.issue = !stat.scan_empty;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/ncs_dp.sv
// Datapath: crystal table, distance pipeline, best-entry tracking and result register.
module ncs_dp
  import ncs_pkg::*;
#(
  parameter int MAX_CRYSTALS = MAX_CRYSTALS_DEF,
  localparam int AW = (MAX_CRYSTALS > 1) ? $clog2(MAX_CRYSTALS) : 1,
  localparam int NW = $clog2(MAX_CRYSTALS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ncs_cmd_t               cmd,
  input  ncs_in_t                in_data,
  input  logic [COUNT_WIDTH-1:0] crystal_count,
  input  logic [MAXD_WIDTH-1:0]  max_distance,
  output ncs_stat_t              stat,
  output logic                   out_valid,
  output ncs_out_t               out_data
);

  localparam int DW1 = COORD_WIDTH + 1;

  // Query context
  logic signed [COORD_WIDTH-1:0] hx_r, hy_r, hz_r;
  logic [NW-1:0]                 n_r;
  logic [AW-1:0]                 last_r;
  logic [LIMIT_WIDTH-1:0]        limit_r;
  logic [AW-1:0]                 addr_r, addr_nxt;
  logic [NW-1:0]                 n_sat;

  assign n_sat = (32'(crystal_count) > MAX_CRYSTALS) ? NW'(MAX_CRYSTALS)
                                                     : NW'(crystal_count);

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      hx_r    <= in_data.pos_x;
      hy_r    <= in_data.pos_y;
      hz_r    <= in_data.pos_z;
      n_r     <= n_sat;
      last_r  <= AW'(n_sat - NW'(1));
      limit_r <= LIMIT_WIDTH'(max_distance) * LIMIT_WIDTH'(max_distance);
    end
  end

  // Scan address
  always_comb begin
    addr_nxt = addr_r;
    if (cmd.query_start) addr_nxt = '0;
    else if (cmd.issue)  addr_nxt = addr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  // Crystal table
  logic                   tbl_we;
  logic [ENTRY_WIDTH-1:0] tbl_rdata;

  assign tbl_we = cmd.load_we && (32'(in_data.entry_index) < MAX_CRYSTALS);

  ncs_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (MAX_CRYSTALS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_data.entry_index)),
    .wdata ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
    .re    (cmd.issue),
    .raddr (addr_r),
    .rdata (tbl_rdata)
  );

  // Pipeline valids and indexes
  logic                   v1_r, v2_r, v3_r, v4_r;
  logic [INDEX_WIDTH-1:0] i1_r, i2_r, i3_r, i4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i1_r <= INDEX_WIDTH'(addr_r);
    i2_r <= i1_r;
    i3_r <= i2_r;
    i4_r <= i3_r;
  end

  // Stage 2: coordinate differences
  logic signed [COORD_WIDTH-1:0] cx, cy, cz;
  logic signed [DW1-1:0]         dx_r, dy_r, dz_r;

  assign {cx, cy, cz} = tbl_rdata;

  always_ff @(posedge clk) begin
    dx_r <= DW1'(cx) - DW1'(hx_r);
    dy_r <= DW1'(cy) - DW1'(hy_r);
    dz_r <= DW1'(cz) - DW1'(hz_r);
  end

  // Stage 3: squares
  logic signed [2*DW1-1:0] px, py, pz;
  logic [SQ_WIDTH-1:0]     sx_r, sy_r, sz_r;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    sx_r <= px[SQ_WIDTH-1:0];
    sy_r <= py[SQ_WIDTH-1:0];
    sz_r <= pz[SQ_WIDTH-1:0];
  end

  // Stage 4: distance sum
  logic [DIST_WIDTH-1:0] dist_r;

  always_ff @(posedge clk) begin
    dist_r <= DIST_WIDTH'(sx_r) + DIST_WIDTH'(sy_r) + DIST_WIDTH'(sz_r);
  end

  // Best entry, strict compare keeps the lowest index on ties
  logic [DIST_WIDTH-1:0]  best_r, best_nxt;
  logic [INDEX_WIDTH-1:0] bidx_r, bidx_nxt;

  always_comb begin
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    if (cmd.query_start) begin
      best_nxt = '1;
      bidx_nxt = '0;
    end else if (v4_r && dist_r < best_r) begin
      best_nxt = dist_r;
      bidx_nxt = i4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '1;
      bidx_r <= '0;
    end else begin
      best_r <= best_nxt;
      bidx_r <= bidx_nxt;
    end
  end

  // Result register
  logic     out_valid_r;
  ncs_out_t out_data_r;
  logic     hit;

  assign hit = (n_r != '0) && (best_r <= DIST_WIDTH'(limit_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data_r.matched       <= hit;
      out_data_r.crystal_index <= hit ? bidx_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status
  assign stat.scan_empty = (n_r == '0);
  assign stat.scan_last  = (addr_r == last_r);
  assign stat.pipe_busy  = v1_r | v2_r | v3_r | v4_r;

endmodule

// File: sv/nearest_crystal_search.sv
// Top level of the nearest crystal search: register port, sequencer and datapath.
//
//   channel   ports                          handshake
//   input     start, busy, in_data           beat when start && !busy
//   result    out_valid, out_data            one-cycle strobe, no back-pressure
//   config    psel/penable/pwrite/paddr/...  APB, pready tied high
//
// Loads may follow each other every cycle.
// A query of n scanned entries (crystal_count saturated to MAX_CRYSTALS) keeps busy
// high through scan, drain (skipped for n = 0) and report; the result strobe comes in
// the first cycle with busy low. The scan reads one table entry per cycle from the
// single read port of the table RAM, followed by a four-stage distance pipeline.
// Reset clears control state and registers; table contents stay undefined until loaded.
module nearest_crystal_search
  import ncs_pkg::*;
#(
  parameter int MAX_CRYSTALS = MAX_CRYSTALS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      start,
  output logic                      busy,
  input  ncs_in_t                   in_data,
  // result channel
  output logic                      out_valid,
  output ncs_out_t                  out_data,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  // Configuration registers
  logic [COUNT_WIDTH-1:0] cfg_count_r;
  logic [MAXD_WIDTH-1:0]  cfg_maxd_r;
  logic                   cfg_wr;
  logic                   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
      cfg_maxd_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_CRYSTAL_COUNT: cfg_count_r <= pwdata[COUNT_WIDTH-1:0];
        REG_MAX_DISTANCE:  cfg_maxd_r  <= pwdata[MAXD_WIDTH-1:0];
        default:           cfg_count_r <= cfg_count_r;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_sel)
      REG_CRYSTAL_COUNT: prdata = CFG_DATA_WIDTH'(cfg_count_r);
      REG_MAX_DISTANCE:  prdata = CFG_DATA_WIDTH'(cfg_maxd_r);
      default:           prdata = '0;
    endcase
  end

  ncs_cmd_t  cmd;
  ncs_stat_t stat;

  ncs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.operation),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  ncs_dp #(
    .MAX_CRYSTALS (MAX_CRYSTALS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_data       (in_data),
    .crystal_count (cfg_count_r),
    .max_distance  (cfg_maxd_r),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

`ifndef ASSERT_OFF
  // A report command yields a result strobe on the next cycle
  a_report_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> out_valid)
    else $error("report without result strobe");

  // No match always reports index zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.matched |-> out_data.crystal_index == '0)
    else $error("unmatched result with nonzero index");

  // An accepted query holds the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.operation == OP_QUERY |=> busy)
    else $error("query accepted but block not busy");

  // Results never come on consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");
`endif

endmodule

// File: dv/tb_top.sv
// Testbench for nearest_crystal_search: table loads, nearest-crystal queries and APB setup.
`timescale 1ns / 1ps

module tb_top;
  import ncs_pkg::*;

  localparam int SETTLE_CYCLES   = 8;
  localparam int REPORT_LIMIT    = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 38;
  localparam int DRAIN_GUARD     = 4096;
  localparam int FILL_COUNT      = 256;
  localparam int LAST_FILL       = FILL_COUNT - 1;
  localparam int MID_FILL        = FILL_COUNT / 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } centre_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  ncs_in_t                   in_data;
  logic                      out_valid;
  ncs_out_t                  out_data;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  // Predictor state: its own copy of the table and the two registers
  centre_t                centre_table [MAX_CRYSTALS_DEF];
  logic [COUNT_WIDTH-1:0] scan_count;
  logic [MAXD_WIDTH-1:0]  accept_radius;
  ncs_out_t               pending_results[$];

  bit idle_on;
  int fail_count;
  int loads_sent;
  int queries_sent;
  int hits_expected;
  int cfg_writes;

  nearest_crystal_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // Nearest entry by squared distance; lowest index wins ties. Returns 1 if a result follows.
  function automatic bit predict_nearest(input ncs_in_t beat, output ncs_out_t res);
    int     n;
    int     i;
    int     best_i;
    longint best;
    longint d;
    longint dx;
    longint dy;
    longint dz;
    longint radius_sq;
    bit     hit;
    res = '0;
    if (beat.operation == OP_LOAD) begin
      centre_table[beat.entry_index] = '{beat.pos_x, beat.pos_y, beat.pos_z};
      return 1'b0;
    end
    n = (scan_count > MAX_CRYSTALS_DEF) ? MAX_CRYSTALS_DEF : int'(scan_count);
    best   = (longint'(1) << DIST_WIDTH) - 1;
    best_i = 0;
    for (i = 0; i < n; i++) begin
      dx = longint'($signed(centre_table[i].x)) - longint'($signed(beat.pos_x));
      dy = longint'($signed(centre_table[i].y)) - longint'($signed(beat.pos_y));
      dz = longint'($signed(centre_table[i].z)) - longint'($signed(beat.pos_z));
      d  = dx * dx + dy * dy + dz * dz;
      if (d < best) begin
        best   = d;
        best_i = i;
      end
    end
    radius_sq = longint'(accept_radius) * longint'(accept_radius);
    hit = (n > 0) && (best <= radius_sq);
    res.crystal_index = hit ? best_i[INDEX_WIDTH-1:0] : '0;
    res.matched       = hit;
    return 1'b1;
  endfunction

  function automatic ncs_in_t make_beat(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                                        input logic [COORD_WIDTH-1:0] x,
                                        input logic [COORD_WIDTH-1:0] y,
                                        input logic [COORD_WIDTH-1:0] z);
    ncs_in_t beat;
    beat.operation   = op;
    beat.entry_index = idx;
    beat.pos_x       = x;
    beat.pos_y       = y;
    beat.pos_z       = z;
    return beat;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    logic [COORD_WIDTH-1:0] c;
    c = COORD_WIDTH'($urandom);
    return c;
  endfunction

  // Coordinate moved by up to +/- spread; wraps at the field width
  function automatic logic [COORD_WIDTH-1:0] jitter(input logic [COORD_WIDTH-1:0] c,
                                                    input int spread);
    int off;
    off = int'($urandom_range(2 * spread)) - spread;
    return c + off[COORD_WIDTH-1:0];
  endfunction

  // One input beat; random idle cycles ahead of it, start held until accepted
  task automatic send_beat(input ncs_in_t beat);
    ncs_out_t res;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (beat.operation == OP_LOAD) loads_sent++;
    else queries_sent++;
    if (predict_nearest(beat, res)) begin
      pending_results.insert(pending_results.size(), res);
      if (res.matched) hits_expected++;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(input logic reg_sel, input logic [CFG_DATA_WIDTH-1:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_CRYSTAL_COUNT) scan_count = value[COUNT_WIDTH-1:0];
    else accept_radius = value[MAXD_WIDTH-1:0];
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    ncs_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result beat: crystal_index %0d matched %0b",
                   out_data.crystal_index, out_data.matched);
      end else begin
        want = pending_results.pop_front();
        if (out_data.crystal_index !== want.crystal_index ||
            out_data.matched !== want.matched) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected index %0d matched %0b, got index %0d matched %0b",
                     want.crystal_index, want.matched,
                     out_data.crystal_index, out_data.matched);
        end
      end
    end
  end

  // Empty table: reset count of zero, then an explicit zero with the widest radius
  task automatic test_empty_table();
    send_beat(make_beat(OP_QUERY, '1, '0, '0, '0));
    write_register(REG_CRYSTAL_COUNT, 0);
    write_register(REG_MAX_DISTANCE, 65535);
    send_beat(make_beat(OP_QUERY, '0, 16'sd32767, -16'sd32768, 16'sd1));
  endtask

  // Coordinate extremes, ties, exact hits and the radius boundary
  task automatic test_nearest_and_threshold();
    send_beat(make_beat(OP_LOAD, 10'd0, -16'sd32768, -16'sd32768, -16'sd32768));
    send_beat(make_beat(OP_LOAD, 10'd1, 16'sd32767, 16'sd32767, 16'sd32767));
    send_beat(make_beat(OP_LOAD, 10'd2, 16'sd0, 16'sd0, 16'sd0));
    send_beat(make_beat(OP_LOAD, 10'd3, 16'sd0, 16'sd0, 16'sd0));
    send_beat(make_beat(OP_LOAD, 10'd4, 16'sd100, 16'sd0, 16'sd0));
    send_beat(make_beat(OP_LOAD, 10'd5, -16'sd20000, 16'sd15000, 16'sd3000));
    send_beat(make_beat(OP_LOAD, 10'd1023, 16'sd12345, -16'sd5432, 16'sd777));
    write_register(REG_CRYSTAL_COUNT, 6);
    write_register(REG_MAX_DISTANCE, 0);
    // exact hits only; entries 2 and 3 tie at the origin
    send_beat(make_beat(OP_QUERY, '1, 16'sd0, 16'sd0, 16'sd0));
    send_beat(make_beat(OP_QUERY, '0, 16'sd32767, 16'sd32767, 16'sd32767));
    send_beat(make_beat(OP_QUERY, '1, -16'sd32768, -16'sd32768, -16'sd32768));
    send_beat(make_beat(OP_QUERY, '0, 16'sd100, 16'sd0, 16'sd0));
    send_beat(make_beat(OP_QUERY, '1, 16'sd1, 16'sd0, 16'sd0));
    // distance of exactly 5 from entry 4
    write_register(REG_MAX_DISTANCE, 5);
    send_beat(make_beat(OP_QUERY, '0, 16'sd103, 16'sd4, 16'sd0));
    write_register(REG_MAX_DISTANCE, 4);
    send_beat(make_beat(OP_QUERY, '1, 16'sd103, 16'sd4, 16'sd0));
    write_register(REG_MAX_DISTANCE, 65535);
    send_beat(make_beat(OP_QUERY, '0, 16'sd32767, -16'sd32768, 16'sd32767));
  endtask

  // Fill the low entries, then long scans over all of them
  task automatic test_large_scan();
    int i;
    for (i = 0; i < FILL_COUNT; i++)
      send_beat(make_beat(OP_LOAD, INDEX_WIDTH'(i), rand_coord(), rand_coord(),
                          rand_coord()));
    write_register(REG_CRYSTAL_COUNT, FILL_COUNT);
    write_register(REG_MAX_DISTANCE, 65535);
    send_beat(make_beat(OP_QUERY, '0, jitter(centre_table[LAST_FILL].x, 50),
                        jitter(centre_table[LAST_FILL].y, 50),
                        jitter(centre_table[LAST_FILL].z, 50)));
    send_beat(make_beat(OP_QUERY, '0, rand_coord(), rand_coord(), rand_coord()));
    write_register(REG_MAX_DISTANCE, 300);
    send_beat(make_beat(OP_QUERY, '1, jitter(centre_table[MID_FILL].x, 20),
                        jitter(centre_table[MID_FILL].y, 20),
                        jitter(centre_table[MID_FILL].z, 20)));
  endtask

  // Random phases; scans stay within the filled low entries
  task automatic test_random_mix();
    int                     phase;
    int                     k;
    int                     r;
    int                     n_eff;
    int                     pick;
    int                     src;
    int                     spread;
    logic [INDEX_WIDTH-1:0] idx;
    logic [COUNT_WIDTH-1:0] count_sel;
    logic [MAXD_WIDTH-1:0]  radius_sel;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) count_sel = COUNT_WIDTH'($urandom_range(2));
      else if (phase == 5) count_sel = COUNT_WIDTH'($urandom_range(FILL_COUNT, MID_FILL));
      else count_sel = COUNT_WIDTH'($urandom_range(64, 1));
      if (phase == 1) radius_sel = '0;
      else if ($urandom_range(3) == 0) radius_sel = '1;
      else radius_sel = MAXD_WIDTH'($urandom_range(400));
      write_register(REG_CRYSTAL_COUNT, CFG_DATA_WIDTH'(count_sel));
      write_register(REG_MAX_DISTANCE, CFG_DATA_WIDTH'(radius_sel));
      n_eff = (count_sel > MAX_CRYSTALS_DEF) ? MAX_CRYSTALS_DEF : int'(count_sel);
      // one phase runs back to back with no idle cycles
      idle_on = (phase != 3);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off until the block has drained completely
        if (phase == 4 && k == ITEMS_PER_PHASE / 2) wait_results();
        r    = int'($urandom_range(99));
        pick = (n_eff > 0) ? int'($urandom_range(n_eff - 1)) : int'($urandom_range(LAST_FILL));
        src  = int'($urandom_range(LAST_FILL));
        if (r < 35) begin
          idx = ($urandom_range(9) < 7) ? INDEX_WIDTH'(pick)
                                        : INDEX_WIDTH'($urandom_range(MAX_CRYSTALS_DEF - 1));
          // a copy of another entry makes ties
          if ($urandom_range(3) == 0)
            send_beat(make_beat(OP_LOAD, idx, centre_table[src].x, centre_table[src].y,
                                centre_table[src].z));
          else
            send_beat(make_beat(OP_LOAD, idx, rand_coord(), rand_coord(), rand_coord()));
        end else if (r < 90) begin
          spread = int'($urandom_range(300));
          send_beat(make_beat(OP_QUERY, INDEX_WIDTH'($urandom_range(MAX_CRYSTALS_DEF - 1)),
                              jitter(centre_table[pick].x, spread),
                              jitter(centre_table[pick].y, spread),
                              jitter(centre_table[pick].z, spread)));
        end else begin
          send_beat(make_beat(OP_QUERY, INDEX_WIDTH'($urandom_range(MAX_CRYSTALS_DEF - 1)),
                              rand_coord(), rand_coord(), rand_coord()));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int guard;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    idle_on = 1'b1;
    scan_count    = '0;
    accept_radius = '0;
    fail_count    = 0;
    loads_sent    = 0;
    queries_sent  = 0;
    hits_expected = 0;
    cfg_writes    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_nearest_and_threshold();
    test_large_scan();
    test_random_mix();

    // drain, then a few more cycles to catch stray results
    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d queries (%0d expected in range), %0d register writes",
             loads_sent, queries_sent, hits_expected, cfg_writes);
    $display("result errors: %0d", fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
